FILE: rtl/core/pgg_pkg.sv
// ----------------------------------------------------------------------------
// pgg_pkg: shared constants of the polar Gaussian generator
// Widths and fixed-point constants used by the sequencer and the multiplier.
// ----------------------------------------------------------------------------
package pgg_pkg;

    localparam int PGG_UNIFORM_BITS = 16;
    localparam int PGG_MUL_W        = 32;
    localparam int PGG_PROD_W       = 2 * PGG_MUL_W;

    // ln 2 in units of 2^-32, rounded.
    localparam logic [31:0] PGG_LN2_Q32 = 32'd2977044472;

endpackage

FILE: rtl/core/pgg_mul.sv
// ----------------------------------------------------------------------------
// pgg_mul: shared unsigned multiplier
// One 32 x 32 bit unsigned multiply per cycle with a registered product.
// ----------------------------------------------------------------------------
module pgg_mul (
    input  logic                           i_clk,
    input  logic [pgg_pkg::PGG_MUL_W-1:0]  i_a,
    input  logic [pgg_pkg::PGG_MUL_W-1:0]  i_b,
    output logic [pgg_pkg::PGG_PROD_W-1:0] o_prod
);
    import pgg_pkg::*;

    logic [PGG_PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PGG_PROD_W'(i_a) * PGG_PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

FILE: rtl/core/polar_gaussian_generator.sv
// ----------------------------------------------------------------------------
// polar_gaussian_generator: Marsaglia polar method, fixed point
// Turns two uniforms into a pair of normal deviates, returns one scaled by the
// standard deviation and offset by the mean, and keeps the other as a spare.
// ----------------------------------------------------------------------------
//  Channel | Direction | tdata (lowest bit first)                 | tuser
//  s       | in        | mean_value 32, std_dev 31, uniform_a 16, | -
//          |           | uniform_b 16, one zero pad bit           |
//  m       | out       | sample_out 32                            | served, from_spare
//
// A request served from the spare goes straight to scaling and hand-over; a
// rejected pair is squared, tested and handed over as a zero result. A fresh
// pair is squared and tested, then runs a binary leading-one search, a
// logarithm by 16 squarings on the shared multiplier, a scaling by ln 2, and,
// for each of the two deviates, a load, a restoring division with a 30-bit
// quotient and a 15-bit square root; it is then scaled, handed over and
// returns to idle.
// The input is ready only in the idle state; a finished result waits in the
// output register, so a new transaction may be accepted while it stalls.
// Reset is synchronous and clears the spare.
// ----------------------------------------------------------------------------
module polar_gaussian_generator #(
    parameter int UNIFORM_BITS = pgg_pkg::PGG_UNIFORM_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // mean_value [31:0], std_dev [62:32], uniform_a [78:63], uniform_b [94:79]
    input  logic [95:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // sample_out [31:0]
    output logic [31:0] o_m_tdata,
    // served [0], from_spare [1]
    output logic [1:0]  o_m_tuser
);
    import pgg_pkg::*;

    localparam int UB_USE = (UNIFORM_BITS < 16) ? UNIFORM_BITS : 16;
    localparam logic [15:0] U_MASK = 16'((32'd1 << UB_USE) - 32'd1);
    localparam int U_SHIFT = 32 - UNIFORM_BITS;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQA, ST_SQB, ST_CHK, ST_NORM, ST_LOGM, ST_LOGU, ST_LMUL,
        ST_LGET, ST_DMUL, ST_DLD, ST_DDIV, ST_DSQ, ST_SMUL, ST_SFIN, ST_DONE
    } t_state;

    t_state r_state;

    // Request registers.
    logic signed [31:0] r_mean;
    logic [30:0]        r_sd;
    logic [16:0]        r_mag_a, r_mag_b;
    logic               r_neg_a, r_neg_b;

    // Working registers.
    logic [32:0] r_sqa;
    logic [31:0] r_sqb;
    logic [31:0] r_s;
    logic [31:0] r_m;
    logic [4:0]  r_k;
    logic [15:0] r_frac;
    logic [21:0] r_l;
    logic [4:0]  r_cnt;
    logic        r_idx;
    logic [31:0] r_rem;
    logic [29:0] r_dsh;
    logic [29:0] r_q;
    logic [29:0] r_x, r_r, r_bit;
    logic signed [15:0] r_spd;
    logic signed [15:0] r_dev;
    logic        r_fsp;
    logic        r_served;
    logic [31:0] r_res;

    // Spare and output.
    logic               r_spare_valid;
    logic signed [15:0] r_spare;
    logic               r_ov;
    logic [31:0]        r_o_data;
    logic [1:0]         r_o_user;

    // Input unpacking and mapping of the uniforms to -1..1.
    logic [31:0] in_mean;
    logic [30:0] in_sd;
    logic [15:0] ua_m, ub_m;
    logic [31:0] ua32, ub32;
    logic [16:0] ua17, ub17;

    assign in_mean = i_s_tdata[31:0];
    assign in_sd   = i_s_tdata[62:32];
    assign ua_m    = i_s_tdata[78:63] & U_MASK;
    assign ub_m    = i_s_tdata[94:79] & U_MASK;
    assign ua32    = 32'(ua_m) << U_SHIFT;
    assign ub32    = 32'(ub_m) << U_SHIFT;
    assign ua17    = ua32[31:15];
    assign ub17    = ub32[31:15];

    // Shared multiplier and its operand selection.
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    pgg_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    logic [21:0] nl;
    logic [15:0] dev_mag;

    assign nl = {6'(6'd32 - {1'b0, r_k}), 16'd0} - {6'd0, r_frac};
    assign dev_mag = r_dev[15] ? 16'(-r_dev) : 16'(r_dev);

    always_comb begin
        mul_a = r_m;
        mul_b = r_m;
        case (r_state)
            ST_SQA:  begin mul_a = 32'(r_mag_a); mul_b = 32'(r_mag_a); end
            ST_SQB:  begin mul_a = 32'(r_mag_b); mul_b = 32'(r_mag_b); end
            ST_LMUL: begin mul_a = 32'(nl);      mul_b = PGG_LN2_Q32;  end
            ST_DMUL: begin
                mul_a = r_idx ? r_sqb : r_sqa[31:0];
                mul_b = 32'(r_l);
            end
            ST_SMUL: begin mul_a = 32'(dev_mag); mul_b = 32'(r_sd);    end
            default: begin mul_a = r_m;          mul_b = r_m;          end
        endcase
    end

    // Combinational helpers for individual steps.
    logic [33:0] s_sum;
    logic [4:0]  norm_n;
    logic [31:0] norm_hi;
    logic [32:0] log_t;
    logic [32:0] div_r2;
    logic        div_ge;
    logic [30:0] sq_rb;
    logic        sq_ge;
    logic [14:0] sq_d;
    logic signed [48:0] sc_t;
    logic signed [36:0] sc_q;
    logic signed [37:0] sc_sum;
    logic [31:0] sc_sat;
    logic        done_fire;

    assign s_sum   = {1'b0, r_sqa} + {2'b0, prod[31:0]} + {1'b0, prod[32], 32'd0};
    assign norm_n  = 5'd16 >> r_cnt[2:0];
    assign norm_hi = ~(32'hFFFF_FFFF >> norm_n);
    assign log_t   = prod[63:31];
    assign div_r2  = {r_rem, r_dsh[29]};
    assign div_ge  = div_r2 >= {1'b0, r_s};
    assign sq_rb   = {1'b0, r_r} + {1'b0, r_bit};
    assign sq_ge   = {1'b0, r_x} >= sq_rb;
    assign sq_d    = sq_ge ? 15'((r_r >> 1) + r_bit) : 15'(r_r >> 1);

    always_comb begin
        if (r_dev[15]) begin
            sc_t = 49'sd2048 - $signed({2'b0, prod[46:0]});
        end else begin
            sc_t = $signed({2'b0, prod[46:0]}) + 49'sd2048;
        end
        sc_q   = 37'(sc_t >>> 12);
        sc_sum = 38'(r_mean) + 38'(sc_q);
        if (sc_sum > 38'sd2147483647) begin
            sc_sat = 32'h7FFF_FFFF;
        end else if (sc_sum < -38'sd2147483648) begin
            sc_sat = 32'h8000_0000;
        end else begin
            sc_sat = sc_sum[31:0];
        end
    end

    assign done_fire = (r_state == ST_DONE) && (!r_ov || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_spare_valid <= 1'b0;
            r_spare       <= '0;
            r_ov          <= 1'b0;
            r_cnt         <= '0;
        end else begin
            if (r_ov && i_m_tready && !done_fire) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_mean  <= $signed(in_mean);
                        r_sd    <= in_sd;
                        r_neg_a <= !ua17[16];
                        r_neg_b <= !ub17[16];
                        r_mag_a <= ua17[16] ? {1'b0, ua17[15:0]} : 17'(17'd65536 - ua17);
                        r_mag_b <= ub17[16] ? {1'b0, ub17[15:0]} : 17'(17'd65536 - ub17);
                        if (r_spare_valid) begin
                            r_dev    <= r_spare;
                            r_fsp    <= 1'b1;
                            r_served <= 1'b1;
                            r_state  <= ST_SMUL;
                        end else begin
                            r_state <= ST_SQA;
                        end
                    end
                end
                ST_SQA: r_state <= ST_SQB;
                ST_SQB: begin
                    r_sqa   <= prod[32:0];
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    // Reject a zero radius and anything on or outside the unit circle.
                    if (s_sum == 34'd0 || s_sum[33:32] != 2'b00) begin
                        r_res    <= '0;
                        r_served <= 1'b0;
                        r_fsp    <= 1'b0;
                        r_state  <= ST_DONE;
                    end else begin
                        r_s     <= s_sum[31:0];
                        r_m     <= s_sum[31:0];
                        r_sqb   <= prod[31:0];
                        r_k     <= 5'd31;
                        r_cnt   <= '0;
                        r_state <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    // Binary leading-one search: steps of 16, 8, 4, 2 and 1.
                    if ((r_m & norm_hi) == 32'd0) begin
                        r_m <= r_m << norm_n;
                        r_k <= r_k - norm_n;
                    end
                    if (r_cnt == 5'd4) begin
                        r_cnt   <= '0;
                        r_frac  <= '0;
                        r_state <= ST_LOGM;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                ST_LOGM: r_state <= ST_LOGU;
                ST_LOGU: begin
                    // Square the mantissa; an overflow past two gives a one bit.
                    r_frac <= {r_frac[14:0], log_t[32]};
                    r_m    <= log_t[32] ? log_t[32:1] : log_t[31:0];
                    if (r_cnt == 5'd15) begin
                        r_state <= ST_LMUL;
                    end else begin
                        r_cnt   <= r_cnt + 5'd1;
                        r_state <= ST_LOGM;
                    end
                end
                ST_LMUL: r_state <= ST_LGET;
                ST_LGET: begin
                    r_l     <= prod[52:31];
                    r_idx   <= 1'b0;
                    r_state <= ST_DMUL;
                end
                ST_DMUL: r_state <= ST_DLD;
                ST_DLD: begin
                    // The quotient fits in 30 bits, so the top 32 bits start below S.
                    r_rem   <= prod[53:22];
                    r_dsh   <= {prod[21:0], 8'd0};
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DDIV;
                end
                ST_DDIV: begin
                    r_rem <= div_ge ? 32'(div_r2 - {1'b0, r_s}) : div_r2[31:0];
                    r_dsh <= {r_dsh[28:0], 1'b0};
                    if (r_cnt == 5'd29) begin
                        r_x     <= {r_q[28:0], div_ge};
                        r_r     <= '0;
                        r_bit   <= 30'd1 << 28;
                        r_cnt   <= '0;
                        r_state <= ST_DSQ;
                    end else begin
                        r_q   <= {r_q[28:0], div_ge};
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                ST_DSQ: begin
                    if (sq_ge) begin
                        r_x <= 30'({1'b0, r_x} - sq_rb);
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_cnt == 5'd14) begin
                        r_cnt <= '0;
                        if (!r_idx) begin
                            r_spd   <= r_neg_a ? -$signed({1'b0, sq_d}) : $signed({1'b0, sq_d});
                            r_idx   <= 1'b1;
                            r_state <= ST_DMUL;
                        end else begin
                            r_dev    <= r_neg_b ? -$signed({1'b0, sq_d}) : $signed({1'b0, sq_d});
                            r_fsp    <= 1'b0;
                            r_served <= 1'b1;
                            r_state  <= ST_SMUL;
                        end
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                ST_SMUL: r_state <= ST_SFIN;
                ST_SFIN: begin
                    r_res   <= sc_sat;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (done_fire) begin
                        r_ov     <= 1'b1;
                        r_o_data <= r_res;
                        r_o_user <= {r_fsp, r_served};
                        if (r_fsp) begin
                            r_spare_valid <= 1'b0;
                        end else if (r_served) begin
                            r_spare_valid <= 1'b1;
                            r_spare       <= r_spd;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_user;

    // A rejected pair carries a zero sample and no spare flag.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_o_user[0] || (r_o_data == 32'd0 && !r_o_user[1])))
        else $error("rejected result is not all zero");

    a_spare_served: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_user[1]) |-> r_o_user[0])
        else $error("spare result not marked as served");

    a_spare_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done_fire && r_fsp) |=> !r_spare_valid)
        else $error("spare still held after use");

    a_spare_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && r_spare_valid) |=> (r_state == ST_SMUL))
        else $error("held spare not used for the next request");

endmodule

FILE: sim/polar_gaussian_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polar_gaussian_generator_tb: self-checking bench for the polar generator
// Requests are queued by an initial block and driven by a clocked driver; a
// clocked monitor compares every result transaction with a bit-exact fixed
// point prediction of the polar method, including the spare deviate path.
// ----------------------------------------------------------------------------
module polar_gaussian_generator_tb;

    localparam int UB        = pgg_pkg::PGG_UNIFORM_BITS;
    localparam int MAX_CYCLE = 2000000;

    typedef struct packed {
        logic [15:0] unif_b;
        logic [15:0] unif_a;
        logic [30:0] sdev;
        logic [31:0] mean;
    } request_t;

    typedef struct packed {
        logic        from_spare;
        logic        served;
        logic [31:0] sample;
    } sample_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [95:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    request_t pending_q[$];
    sample_t  expected_q[$];
    int       n_err;
    int       n_cycle;
    bit       calm;

    // Predictor state: the held spare deviate.
    bit          pred_spare_ok;
    logic signed [31:0] pred_spare;

    polar_gaussian_generator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // -log2(s) in Q.16 for s = sq / 2^32; fraction bits by repeated squaring.
    function automatic longint unsigned neg_log2(longint unsigned sq);
        int unsigned     k;
        longint unsigned m, frac;
        k = 31;
        frac = 0;
        while (k > 0 && sq[k] == 1'b0) k--;
        m = sq << (31 - k);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 31;
            frac <<= 1;
            if (m >= 64'h1_0000_0000) begin
                frac |= 1;
                m >>= 1;
            end
        end
        return (64'd32 << 16) - ((longint'(k) << 16) + frac);
    endfunction

    function automatic longint signed centre_uniform(logic [15:0] u);
        longint unsigned w;
        w = (longint'(u) & ((64'd1 << UB) - 1)) << (32 - UB);
        return longint'(w >> 15) - 65536;
    endfunction

    function automatic logic signed [31:0] polar_deviate(longint signed v,
            longint unsigned lg, longint unsigned sq);
        longint unsigned mag, d;
        mag = (v < 0) ? -v : v;
        d = int_sqrt((mag * mag * lg * 256) / sq);
        if (d > 32767) d = 32767;
        return (v < 0) ? -$signed(d[31:0]) : $signed(d[31:0]);
    endfunction

    function automatic logic [31:0] scale_offset(request_t r, logic signed [31:0] d);
        longint signed t, q, sum;
        t = longint'(d) * longint'({1'b0, r.sdev}) + 2048;
        q = (t >= 0) ? t / 4096 : -((-t + 4095) / 4096);
        sum = longint'($signed(r.mean)) + q;
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        return sum[31:0];
    endfunction

    function automatic sample_t predict_sample(request_t r);
        sample_t         e;
        longint signed   va, vb;
        longint unsigned sq, lg;
        e = '0;
        if (pred_spare_ok) begin
            pred_spare_ok = 1'b0;
            e.sample = scale_offset(r, pred_spare);
            e.served = 1'b1;
            e.from_spare = 1'b1;
            return e;
        end
        va = centre_uniform(r.unif_a);
        vb = centre_uniform(r.unif_b);
        sq = va * va + vb * vb;
        // Rejected pair: s of zero or at least one leaves the spare alone.
        if (sq == 0 || sq >= 64'h1_0000_0000) return e;
        lg = (neg_log2(sq) * 64'(pgg_pkg::PGG_LN2_Q32) * 2) >> 32;
        pred_spare = polar_deviate(va, lg, sq);
        pred_spare_ok = 1'b1;
        e.sample = scale_offset(r, polar_deviate(vb, lg, sq));
        e.served = 1'b1;
        return e;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, n_cycle);
        n_err++;
    endtask

    function automatic request_t rand_request();
        request_t r;
        r.mean = $urandom;
        case ($urandom_range(0, 3))
            0: r.sdev = 31'($urandom);
            1: r.sdev = 31'($urandom_range(0, 32'h0010_0000));
            default: r.sdev = 31'($urandom_range(0, 32'h0004_0000));
        endcase
        if ($urandom_range(0, 9) == 0) r.mean = $urandom_range(0, 1) ? 32'h7fff_ffff
                                                                      : 32'h8000_0000;
        r.unif_a = $urandom;
        r.unif_b = $urandom;
        // Occasionally aim at corners: centre (s zero) and the unit circle edge.
        if ($urandom_range(0, 19) == 0) begin
            r.unif_a = 16'h8000;
            r.unif_b = 16'h8000;
        end else if ($urandom_range(0, 19) == 0) begin
            r.unif_a = 16'h0000;
            r.unif_b = 16'h8000 + 16'($urandom_range(0, 2));
        end
        return r;
    endfunction

    function automatic request_t make_request(logic [31:0] m, logic [30:0] s,
            logic [15:0] a, logic [15:0] b);
        request_t r;
        r.mean = m;
        r.sdev = s;
        r.unif_a = a;
        r.unif_b = b;
        return r;
    endfunction

    // Driver: presents queued requests; the prediction is made on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_q.push_back(predict_sample(request_t'(i_s_tdata[94:0])));
                void'(pending_q.pop_front());
            end
            if (pending_q.size() > 0 && (!i_s_tvalid || o_s_tready)
                    && !(i_s_tvalid && o_s_tready && pending_q.size() == 1)) begin
                if (i_s_tvalid && o_s_tready) begin
                    // Next entry in the queue is already the new head.
                    if (calm || $urandom_range(0, 99) >= 18) begin
                        i_s_tvalid <= 1'b1;
                        i_s_tdata  <= {1'b0, pending_q[0]};
                    end else begin
                        i_s_tvalid <= 1'b0;
                    end
                end else if (calm || $urandom_range(0, 99) >= 18) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {1'b0, pending_q[0]};
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end else if (i_s_tvalid && o_s_tready) begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transaction and stalls the output at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", o_m_tdata, 32'h0);
                end else begin
                    sample_t e;
                    e = expected_q.pop_front();
                    if (o_m_tdata !== e.sample)
                        report_mismatch("sample_out", o_m_tdata, e.sample);
                    if (o_m_tuser[0] !== e.served)
                        report_mismatch("served", o_m_tuser[0], e.served);
                    if (o_m_tuser[1] !== e.from_spare)
                        report_mismatch("from_spare", o_m_tuser[1], e.from_spare);
                end
            end
            i_m_tready <= calm || ($urandom_range(0, 99) >= 18);
        end
    end

    always @(posedge i_clk) begin
        n_cycle <= n_cycle + 1;
        if (n_cycle > MAX_CYCLE) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        n_err = 0;
        n_cycle = 0;
        calm = 1'b0;
        pred_spare_ok = 1'b0;
        pred_spare = '0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: centre point, edges, extreme means and deviations.
        pending_q.push_back(make_request(32'h0, 31'h0001_0000, 16'h8000, 16'h8000));
        pending_q.push_back(make_request(32'h0, 31'h0001_0000, 16'h0000, 16'h0000));
        pending_q.push_back(make_request(32'h0, 31'h0001_0000, 16'h0000, 16'h8000));
        pending_q.push_back(make_request(32'h0, 31'h0001_0000, 16'h0000, 16'h8001));
        pending_q.push_back(make_request(32'h0, 31'h0001_0000, 16'h8000, 16'h8001));
        pending_q.push_back(make_request(32'h7fff_ffff, 31'h7fff_ffff, 16'hffff, 16'h8000));
        pending_q.push_back(make_request(32'h8000_0000, 31'h7fff_ffff, 16'h8000, 16'h0001));
        pending_q.push_back(make_request(32'h8000_0000, 31'h7fff_ffff, 16'h4000, 16'h4000));
        pending_q.push_back(make_request(32'h7fff_ffff, 31'h7fff_ffff, 16'hc000, 16'hc000));
        pending_q.push_back(make_request(32'hffff_ffff, 31'h0, 16'h7fff, 16'h8000));
        pending_q.push_back(make_request(32'h1234_5678, 31'h0, 16'hffff, 16'hffff));
        pending_q.push_back(make_request(32'h0, 31'h0000_0001, 16'h8000, 16'hffff));
        pending_q.push_back(make_request(32'hdead_beef, 31'h5555_5555, 16'haaaa, 16'h5555));
        pending_q.push_back(make_request(32'h0, 31'h2aaa_aaaa, 16'h5555, 16'haaaa));

        // Random requests; the first stretch runs without any idling.
        calm = 1'b1;
        for (int i = 0; i < 600; i++) begin
            if (i == 150) begin
                wait (pending_q.size() == 0);
                calm = 1'b0;
            end
            pending_q.push_back(rand_request());
        end

        wait (pending_q.size() == 0 && !i_s_tvalid);
        wait (expected_q.size() == 0);
        repeat (300) @(posedge i_clk);
        if (n_err == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
